// File: hdl/largest_rectangle_in_mask_defines.svh
// Assertion macros used by the largest-rectangle top level.
`ifndef LARGEST_RECTANGLE_IN_MASK_DEFINES_SVH
`define LARGEST_RECTANGLE_IN_MASK_DEFINES_SVH

// Same-cycle implication, clocked on aclk and off while aresetn is low.
`define LRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and off while aresetn is low.
`define LRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lrm_pkg.sv
// Types, constants and codes shared by the largest-rectangle block.
`default_nettype none

package lrm_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = $clog2(MAX_COLS + 1);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int H_W       = $clog2(MAX_ROWS + 1);
    localparam int AREA_W    = 21;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE  = 1'b1;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RST = CFG_W'(1024);
    localparam logic [CFG_W-1:0] MIN_SIDE_RST  = CFG_W'(1);

    typedef struct packed {
        logic usable;
        logic last_cell;
    } in_beat_t;

    typedef struct packed {
        logic              found;
        logic [AREA_W-1:0] best_area;
        logic [9:0]        left_col;
        logic [9:0]        right_col;
        logic [9:0]        top_row;
        logic [9:0]        bottom_row;
    } out_beat_t;

    // One column stack entry: the column and its bar height.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [H_W-1:0]   h;
    } stk_entry_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clear;
    } hist_ctrl_t;

    typedef struct packed {
        logic push;
        logic rd;
        logic pop;
        logic clear;
    } stk_ctrl_t;

    typedef struct packed {
        logic mul;
        logic commit;
        logic clear;
    } score_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HREAD,
        ST_HCALC,
        ST_POP_TEST,
        ST_POP_MUL,
        ST_POP_CMP,
        ST_EMIT
    } state_t;

    // What the sequencer does once the pop loop has finished.
    typedef enum logic [1:0] {
        CONT_TAKE,
        CONT_PUSH,
        CONT_ROW,
        CONT_LAST
    } cont_t;

endpackage

`default_nettype wire

// File: hdl/largest_rectangle_in_mask.sv
// Top level of the largest all-usable rectangle finder over a streamed mask.
// Each cell reads and updates its column height, then the pop loop sends each column popped
// off the stack through the shared multiply-and-compare unit; a row end adds a closing pass.
// The last cell also runs the rest of its row as unusable cells, then the result beat.
// After reset and after each result a sweep clears the height memory.
`default_nettype none

`include "largest_rectangle_in_mask_defines.svh"

module largest_rectangle_in_mask import lrm_pkg::*; (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_addr,
    input  wire [CFG_W-1:0]      cfg_wr_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire in_beat_t        s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output out_beat_t            m_data
);

    state_t           state_reg, state_next;
    cont_t            cont_reg, cont_next;
    logic [CNT_W-1:0] col_idx_reg, col_idx_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] pop_col_reg, pop_col_next;
    logic [H_W-1:0]   pop_h_reg, pop_h_next;
    logic             use_reg, use_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;
    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] min_side_reg;

    logic [CNT_W-1:0] width_eff;
    logic [CFG_W-1:0] min_eff;
    logic [CNT_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             cell_acc;
    logic             pop_go;
    logic             emit_go;

    hist_ctrl_t       hist_ctrl;
    logic [H_W-1:0]   h_new;
    logic             hist_busy;
    stk_ctrl_t        stk_ctrl;
    stk_entry_t       stk_push;
    stk_entry_t       stk_top;
    stk_entry_t       stk_below;
    logic [CNT_W-1:0] stk_count;
    score_ctrl_t      score_ctrl;
    out_beat_t        score_best;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RST;
            min_side_reg  <= MIN_SIDE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ROW_WIDTH: row_width_reg <= cfg_wr_data;
                CFG_MIN_SIDE:  min_side_reg  <= cfg_wr_data;
            endcase
        end
    end

    // Effective settings and shared conditions.
    always_comb begin
        if (row_width_reg == '0) begin
            width_eff = CNT_W'(1);
        end else if (CNT_W'(row_width_reg) > CNT_W'(MAX_COLS)) begin
            width_eff = CNT_W'(MAX_COLS);
        end else begin
            width_eff = CNT_W'(row_width_reg);
        end
        min_eff  = (min_side_reg == '0) ? CFG_W'(1) : min_side_reg;
        col_inc  = col_idx_reg + CNT_W'(1);
        row_inc  = (row_reg == ROW_W'(MAX_ROWS - 1)) ? row_reg : (row_reg + ROW_W'(1));
        cell_acc = s_valid && s_ready;
        pop_go   = (stk_count != '0) && (stk_top.h >= pop_h_reg);
        emit_go  = !m_valid_reg || m_ready;
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (!hist_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cell_acc) begin
                    state_next = (col_idx_reg >= width_eff) ? ST_POP_TEST : ST_HREAD;
                end
            end
            ST_HREAD: state_next = ST_HCALC;
            ST_HCALC: state_next = ST_POP_TEST;
            ST_POP_TEST: begin
                if (pop_go) begin
                    state_next = ST_POP_MUL;
                end else begin
                    unique case (cont_reg)
                        CONT_TAKE: state_next = ST_HREAD;
                        CONT_ROW:  state_next = ST_IDLE;
                        CONT_LAST: state_next = ST_EMIT;
                        CONT_PUSH: begin
                            if (last_reg && (col_inc < width_eff)) begin
                                state_next = ST_HREAD;
                            end else if (last_reg || (col_inc >= width_eff)) begin
                                state_next = ST_POP_TEST;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_POP_MUL: state_next = ST_POP_CMP;
            ST_POP_CMP: state_next = ST_POP_TEST;
            ST_EMIT: begin
                if (emit_go) begin
                    state_next = ST_CLEAR;
                end
            end
        endcase
    end

    // Sequencer outputs to the memories and the scoring unit.
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        hist_ctrl        = '0;
        stk_ctrl         = '0;
        score_ctrl       = '0;
        stk_push.col     = col_idx_reg[COL_W-1:0];
        stk_push.h       = pop_h_reg;
        unique case (state_reg)
            ST_HREAD: hist_ctrl.rd = 1'b1;
            ST_HCALC: hist_ctrl.wr = 1'b1;
            ST_POP_TEST: begin
                if (pop_go) begin
                    stk_ctrl.rd = (stk_count >= CNT_W'(2));
                end else if (cont_reg == CONT_PUSH) begin
                    stk_ctrl.push = 1'b1;
                end else if ((cont_reg == CONT_TAKE) || (cont_reg == CONT_ROW)) begin
                    stk_ctrl.clear = 1'b1;
                end
            end
            ST_POP_MUL: score_ctrl.mul = 1'b1;
            ST_POP_CMP: begin
                score_ctrl.commit = 1'b1;
                stk_ctrl.pop      = 1'b1;
            end
            ST_EMIT: begin
                hist_ctrl.clear  = emit_go;
                stk_ctrl.clear   = emit_go;
                score_ctrl.clear = emit_go;
            end
            ST_CLEAR, ST_IDLE: begin
            end
        endcase
    end

    // Datapath register next values.
    always_comb begin
        cont_next    = cont_reg;
        col_idx_next = col_idx_reg;
        row_next     = row_reg;
        pop_col_next = pop_col_reg;
        pop_h_next   = pop_h_reg;
        use_next     = use_reg;
        last_next    = last_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if ((state_reg == ST_IDLE) && cell_acc) begin
            use_next  = s_data.usable;
            last_next = s_data.last_cell;
            // A narrowed row width closes the current row before the cell is taken.
            if (col_idx_reg >= width_eff) begin
                pop_col_next = col_idx_reg;
                pop_h_next   = '0;
                cont_next    = CONT_TAKE;
            end
        end

        if (state_reg == ST_HCALC) begin
            pop_col_next = col_idx_reg;
            pop_h_next   = h_new;
            cont_next    = CONT_PUSH;
        end

        if ((state_reg == ST_POP_TEST) && !pop_go) begin
            case (cont_reg) inside
                CONT_TAKE, CONT_ROW: begin
                    col_idx_next = '0;
                    row_next     = row_inc;
                end
                CONT_PUSH: begin
                    col_idx_next = col_inc;
                    if (last_reg && (col_inc < width_eff)) begin
                        // The rest of the final row counts as unusable.
                        use_next = 1'b0;
                    end else if (last_reg || (col_inc >= width_eff)) begin
                        pop_col_next = col_inc;
                        pop_h_next   = '0;
                        cont_next    = last_reg ? CONT_LAST : CONT_ROW;
                    end
                end
                default: begin
                end
            endcase
        end

        if ((state_reg == ST_EMIT) && emit_go) begin
            m_data_next  = score_best;
            m_valid_next = 1'b1;
            col_idx_next = '0;
            row_next     = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cont_reg    <= CONT_TAKE;
            col_idx_reg <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cont_reg    <= cont_next;
            col_idx_reg <= col_idx_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pop_col_reg <= pop_col_next;
        pop_h_reg   <= pop_h_next;
        use_reg     <= use_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    lrm_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (hist_ctrl),
        .addr     (col_idx_reg[COL_W-1:0]),
        .use_cell (use_reg),
        .h_new    (h_new),
        .busy     (hist_busy)
    );

    lrm_stack u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (stk_ctrl),
        .push_entry (stk_push),
        .top        (stk_top),
        .below      (stk_below),
        .count      (stk_count)
    );

    lrm_score u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (score_ctrl),
        .bar_h     (stk_top.h),
        .below     (stk_below),
        .has_below (stk_count >= CNT_W'(2)),
        .end_col   (pop_col_reg),
        .row_idx   (row_reg),
        .min_side  (min_eff),
        .best      (score_best)
    );

    // Checks on the sequencer.
    `LRM_ASSERT_NEXT(a_busy_after_beat, s_valid && s_ready, !s_ready, "cell beat taken while busy")
    `LRM_ASSERT_NOW(a_pop_nonempty, (state_reg == ST_POP_MUL) || (state_reg == ST_POP_CMP), stk_count != '0, "pop from an empty stack")
    `LRM_ASSERT_NEXT(a_result_loaded, (state_reg == ST_EMIT) && (!m_valid_reg || m_ready), m_valid_reg, "result beat not loaded")
    `LRM_ASSERT_NOW(a_no_beat_in_sweep, hist_busy, !s_ready, "cell beat offered during clearing sweep")

endmodule

`default_nettype wire

// File: hdl/lrm_hist.sv
// Column height memory with saturating update and a clearing sweep.
`default_nettype none

module lrm_hist import lrm_pkg::*; (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire hist_ctrl_t  ctrl,
    input  wire [COL_W-1:0]  addr,
    input  wire              use_cell,
    output logic [H_W-1:0]   h_new,
    output logic             busy
);

    logic [H_W-1:0]   mem [MAX_COLS];
    logic [H_W-1:0]   rd_data_reg;
    logic [COL_W-1:0] clr_cnt_reg;
    logic             busy_reg;

    // Clearing sweep: zeroes every entry in turn after reset or on request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (ctrl.clear) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
            if (clr_cnt_reg == COL_W'(MAX_COLS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (ctrl.wr) begin
            mem[addr] <= h_new;
        end
        if (ctrl.rd) begin
            rd_data_reg <= mem[addr];
        end
    end

    // New height: one more than before, capped, or zero for an unusable cell.
    always_comb begin
        if (!use_cell) begin
            h_new = '0;
        end else if (rd_data_reg >= H_W'(MAX_ROWS)) begin
            h_new = H_W'(MAX_ROWS);
        end else begin
            h_new = rd_data_reg + H_W'(1);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: hdl/lrm_stack.sv
// Column stack: top entry in registers, lower entries in a memory.
`default_nettype none

module lrm_stack import lrm_pkg::*; (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire stk_ctrl_t   ctrl,
    input  wire stk_entry_t  push_entry,
    output stk_entry_t       top,
    output stk_entry_t       below,
    output logic [CNT_W-1:0] count
);

    stk_entry_t       mem [MAX_COLS];
    stk_entry_t       top_reg;
    stk_entry_t       below_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    logic             push_ok;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign push_ok = ctrl.push && (count_reg < CNT_W'(MAX_COLS));

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.clear) begin
            count_reg <= '0;
        end else if (push_ok) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_reg <= cnt_m1;
        end
    end

    // A push spills the old top into memory; a pop takes the prefetched entry below.
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            top_reg <= push_entry;
            if (count_reg != '0) begin
                mem[cnt_m1[COL_W-1:0]] <= top_reg;
            end
        end else if (ctrl.pop) begin
            top_reg <= below_reg;
        end
        if (ctrl.rd) begin
            below_reg <= mem[cnt_m2[COL_W-1:0]];
        end
    end

    assign top   = top_reg;
    assign below = below_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

// File: hdl/lrm_score.sv
// Shared scoring unit: span width, area product and best-rectangle update.
`default_nettype none

module lrm_score import lrm_pkg::*; (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire score_ctrl_t  ctrl,
    input  wire [H_W-1:0]     bar_h,
    input  wire stk_entry_t   below,
    input  wire               has_below,
    input  wire [CNT_W-1:0]   end_col,
    input  wire [ROW_W-1:0]   row_idx,
    input  wire [CFG_W-1:0]   min_side,
    output out_beat_t         best
);

    logic [CNT_W-1:0]       left;
    logic [CNT_W-1:0]       span;
    logic [H_W+CNT_W-1:0]   prod;
    logic [AREA_W-1:0]      area_reg;
    logic [CNT_W-1:0]       span_reg;
    logic [COL_W-1:0]       left_reg;
    logic [H_W-1:0]         h_reg;
    logic [CNT_W-1:0]       endc_reg;
    logic [CNT_W-1:0]       row_p1;
    logic [CNT_W-1:0]       top_calc;
    logic [CNT_W-1:0]       right_calc;
    logic                   hit;

    logic [AREA_W-1:0]      best_area_reg;
    logic [COL_W-1:0]       best_left_reg;
    logic [COL_W-1:0]       best_right_reg;
    logic [ROW_W-1:0]       best_top_reg;
    logic [ROW_W-1:0]       best_bottom_reg;

    // The span runs from just after the bar below up to the closing column.
    always_comb begin
        left = has_below ? (CNT_W'(below.col) + CNT_W'(1)) : '0;
        span = (end_col >= left) ? (end_col - left) : '0;
        prod = bar_h * span;
    end

    // Product stage.
    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            area_reg <= prod[AREA_W-1:0];
            span_reg <= span;
            left_reg <= left[COL_W-1:0];
            h_reg    <= bar_h;
            endc_reg <= end_col;
        end
    end

    // Compare stage; a tie keeps the earlier rectangle.
    always_comb begin
        row_p1     = CNT_W'(row_idx) + CNT_W'(1);
        top_calc   = (row_p1 >= CNT_W'(h_reg)) ? (row_p1 - CNT_W'(h_reg)) : '0;
        right_calc = endc_reg - CNT_W'(1);
        hit        = (h_reg >= H_W'(min_side)) && (span_reg >= CNT_W'(min_side))
                     && (area_reg > best_area_reg) && (endc_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            best_area_reg   <= '0;
            best_left_reg   <= '0;
            best_right_reg  <= '0;
            best_top_reg    <= '0;
            best_bottom_reg <= '0;
        end else if (ctrl.commit && hit) begin
            best_area_reg   <= area_reg;
            best_left_reg   <= left_reg;
            best_right_reg  <= right_calc[COL_W-1:0];
            best_top_reg    <= top_calc[ROW_W-1:0];
            best_bottom_reg <= row_idx;
        end
    end

    always_comb begin
        best.found      = (best_area_reg != '0);
        best.best_area  = best_area_reg;
        best.left_col   = 10'(best_left_reg);
        best.right_col  = 10'(best_right_reg);
        best.top_row    = 10'(best_top_reg);
        best.bottom_row = 10'(best_bottom_reg);
    end

endmodule

`default_nettype wire

// File: sim/max_rect_check_pkg.sv
// Scoreboard class that predicts and checks the largest-rectangle result beats.
package max_rect_check_pkg;
    import lrm_pkg::*;

    class max_rect_checker;
        // Register copies, as written.
        int unsigned width_reg;
        int unsigned min_reg;

        // Histogram scan state, mirrored one for one with the block.
        int unsigned heights[MAX_COLS];
        int unsigned stack_cols[MAX_COLS];
        int unsigned stack_depth;
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned area_best;
        int unsigned left_best;
        int unsigned right_best;
        int unsigned top_best;
        int unsigned bottom_best;

        // Result beats still owed by the block, oldest first.
        out_beat_t   pending_rects[$];
        int          mismatches;

        function new();
            width_reg  = ROW_WIDTH_RST;
            min_reg    = MIN_SIDE_RST;
            mismatches = 0;
            clear_grid();
        endfunction

        function void clear_grid();
            foreach (heights[i]) begin
                heights[i]    = 0;
                stack_cols[i] = 0;
            end
            stack_depth = 0;
            col_pos     = 0;
            row_pos     = 0;
            area_best   = 0;
            left_best   = 0;
            right_best  = 0;
            top_best    = 0;
            bottom_best = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_ROW_WIDTH) begin
                width_reg = value;
            end else if (idx == CFG_MIN_SIDE) begin
                min_reg = value;
            end
        endfunction

        // A width of zero behaves as one column; anything wider than the memory is clipped.
        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_COLS) return MAX_COLS;
            return width_reg;
        endfunction

        function int unsigned eff_min();
            return (min_reg == 0) ? 1 : min_reg;
        endfunction

        // Pop every bar at least as tall as h and score the span that ends just before col.
        function void pop_bars(int unsigned col, int unsigned h);
            int unsigned mn;
            int unsigned top;
            int unsigned hh;
            int unsigned left;
            int unsigned span;
            int unsigned area;
            mn = eff_min();
            while (stack_depth > 0) begin
                top = stack_cols[(stack_depth - 1) % MAX_COLS] % MAX_COLS;
                hh  = heights[top];
                if (hh < h) break;
                stack_depth--;
                left = (stack_depth != 0) ? stack_cols[(stack_depth - 1) % MAX_COLS] + 1 : 0;
                span = (col >= left) ? col - left : 0;
                area = hh * span;
                // Strictly larger only, so the first rectangle found wins a tie.
                if (hh >= mn && span >= mn && area > area_best && col > 0) begin
                    area_best   = area;
                    left_best   = left;
                    right_best  = col - 1;
                    bottom_best = row_pos;
                    top_best    = (row_pos + 1 >= hh) ? row_pos + 1 - hh : 0;
                end
            end
        endfunction

        function void take_cell(int unsigned col, bit cell_ok);
            int unsigned c;
            int unsigned h;
            c = col % MAX_COLS;
            h = cell_ok ? heights[c] + 1 : 0;
            if (h > MAX_ROWS) h = MAX_ROWS;
            heights[c] = h;
            pop_bars(c, h);
            if (stack_depth < MAX_COLS) begin
                stack_cols[stack_depth] = c;
                stack_depth++;
            end
        endfunction

        // Close the row with a zero-height sentinel; the row count saturates.
        function void close_row(int unsigned col);
            pop_bars(col, 0);
            stack_depth = 0;
            col_pos     = 0;
            if (row_pos < MAX_ROWS - 1) row_pos++;
        endfunction

        // Advance the prediction by one accepted input beat.
        function void feed_cell(in_beat_t beat);
            int unsigned w;
            int unsigned c;
            out_beat_t   want;
            w = eff_width();
            // A row width lowered under the current column closes the row first.
            if (col_pos >= w) close_row(col_pos);
            take_cell(col_pos, beat.usable);
            col_pos++;
            if (beat.last_cell) begin
                // The rest of a part-filled row counts as unusable.
                for (c = col_pos; c < w; c++) take_cell(c, 1'b0);
                close_row((w > col_pos) ? w : col_pos);
                want.found      = (area_best > 0);
                want.best_area  = AREA_W'(area_best);
                want.left_col   = 10'(left_best);
                want.right_col  = 10'(right_best);
                want.top_row    = 10'(top_best);
                want.bottom_row = 10'(bottom_best);
                pending_rects.insert(pending_rects.size(), want);
                clear_grid();
            end else if (col_pos >= w) begin
                close_row(w);
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("tb: mismatch at %0t: %s", $time, what);
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(out_beat_t got);
            out_beat_t want;
            if (pending_rects.size() == 0) begin
                report("result beat with no grid outstanding");
                return;
            end
            want = pending_rects.pop_front();
            if (got.found !== want.found)
                report($sformatf("found: got %0d, expected %0d", got.found, want.found));
            if (got.best_area !== want.best_area)
                report($sformatf("best_area: got %0d, expected %0d",
                                 got.best_area, want.best_area));
            if (got.left_col !== want.left_col)
                report($sformatf("left_col: got %0d, expected %0d",
                                 got.left_col, want.left_col));
            if (got.right_col !== want.right_col)
                report($sformatf("right_col: got %0d, expected %0d",
                                 got.right_col, want.right_col));
            if (got.top_row !== want.top_row)
                report($sformatf("top_row: got %0d, expected %0d",
                                 got.top_row, want.top_row));
            if (got.bottom_row !== want.bottom_row)
                report($sformatf("bottom_row: got %0d, expected %0d",
                                 got.bottom_row, want.bottom_row));
        endtask
    endclass

endpackage

// File: sim/tb_top.sv
// Testbench top: streams masks into the largest-rectangle block and checks each result beat.
module tb_top;
    import lrm_pkg::*;
    import max_rect_check_pkg::*;

    localparam int IDLE_LIMIT   = 50000;
    localparam int CLEAR_SETTLE = 1100;
    localparam int CELL_SETTLE  = 100;
    localparam int RANDOM_CELLS = 420;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr    = CFG_ROW_WIDTH;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b1;
    out_beat_t            m_data;

    max_rect_checker sb;
    int  cells_sent  = 0;
    int  idle_cycles = 0;
    int  rx_hold     = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;

    largest_rectangle_in_mask dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: after each beat draw a stall that starts once the next result is offered.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            sb.check_result(m_data);
            rx_hold <= rx_calm ? 0 : $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else if (!m_ready && (rx_hold == 0 || m_valid)) begin
            if (rx_hold <= 1) begin
                m_ready <= 1'b1;
            end else begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    // Watchdog: give up when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one cell after a random gap and wait for the block to take it.
    task automatic send_cell(input logic cell_ok, input logic is_last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= in_beat_t'{usable: cell_ok, last_cell: is_last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.feed_cell(s_data);
        cells_sent++;
    endtask

    // Send count cells from mask, least significant bit first.
    task automatic send_cells(input logic [31:0] mask, input int count, input bit ends_grid);
        int i;
        for (i = 0; i < count; i++) send_cell(mask[i], ends_grid && (i == count - 1));
    endtask

    // Hold the sender until every result is in, then let the block settle.
    task automatic await_results(input int settle);
        s_valid <= 1'b0;
        while (sb.pending_rects.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, value);
        @(posedge aclk);
    endtask

    // Mostly narrow grids; now and then the extremes or a wide row.
    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_W'(2047);
            2:       return CFG_W'(MAX_COLS);
            3:       return CFG_W'($urandom_range(9, 2047));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_min();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'(2047);
            2:       return CFG_W'(MAX_COLS);
            default: return CFG_W'($urandom_range(1, 3));
        endcase
    endfunction

    initial begin
        int first_random;
        int w_eff;
        int cells;
        int density;
        int n;

        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset widths: one usable cell, the block runs out the rest of the wide row.
        send_cell(1'b1, 1'b1);

        // Zero in both registers behaves as one.
        await_results(CLEAR_SETTLE);
        write_reg(CFG_ROW_WIDTH, '0);
        write_reg(CFG_MIN_SIDE, '0);
        send_cells(32'b111, 3, 1'b1);

        // Register maxima: width clipped, minimum larger than any grid.
        await_results(CLEAR_SETTLE);
        write_reg(CFG_ROW_WIDTH, CFG_W'(2047));
        write_reg(CFG_MIN_SIDE, CFG_W'(2047));
        send_cell(1'b1, 1'b1);

        // Three by three grid with a minimum side of two.
        await_results(CLEAR_SETTLE);
        write_reg(CFG_ROW_WIDTH, CFG_W'(3));
        write_reg(CFG_MIN_SIDE, CFG_W'(2));
        send_cells(32'b010_111_111, 9, 1'b1);

        // Width lowered mid-row, then raised mid-grid; unvisited columns keep their height.
        await_results(CLEAR_SETTLE);
        write_reg(CFG_ROW_WIDTH, CFG_W'(4));
        write_reg(CFG_MIN_SIDE, CFG_W'(1));
        send_cells(32'b111, 3, 1'b0);
        await_results(CELL_SETTLE);
        write_reg(CFG_ROW_WIDTH, CFG_W'(2));
        send_cells(32'b11, 2, 1'b0);
        await_results(CELL_SETTLE);
        write_reg(CFG_ROW_WIDTH, CFG_W'(4));
        send_cells(32'b0111, 4, 1'b1);

        // Random grids, each closed by a last cell, some of them cut off mid-row.
        first_random = cells_sent;
        while (cells_sent - first_random < RANDOM_CELLS) begin
            if ($urandom_range(0, 1) == 0) begin
                await_results(CLEAR_SETTLE);
                write_reg(CFG_ROW_WIDTH, pick_width());
                write_reg(CFG_MIN_SIDE, pick_min());
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       density = 50;
                1:       density = 75;
                default: density = 90;
            endcase
            w_eff = sb.eff_width();
            if (w_eff > 16) begin
                cells = $urandom_range(1, 12);
            end else begin
                cells = w_eff * $urandom_range(1, 6);
                if ($urandom_range(0, 3) == 0) cells = $urandom_range(1, cells);
            end
            for (n = 0; n < cells; n++)
                send_cell($urandom_range(0, 99) < density, n == cells - 1);
        end

        // Drain, then leave room for any stray result beat.
        await_results(CLEAR_SETTLE);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: largest_rectangle_in_mask.f
+incdir+hdl
hdl/lrm_pkg.sv
hdl/lrm_hist.sv
hdl/lrm_stack.sv
hdl/lrm_score.sv
hdl/largest_rectangle_in_mask.sv
sim/max_rect_check_pkg.sv
sim/tb_top.sv
